// ===== hw/rtl/rkr_pkg.sv =====
// Package for the remote key repeat filter: event kinds, register indexes,
// default widths and the control struct passed from the core to the top level.
// No dependencies.
`default_nettype none

package rkr_pkg;

  localparam int KEY_WIDTH_DEF  = 32;
  localparam int TIME_WIDTH_DEF = 16;
  localparam int CFG_WIDTH      = 16;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int COUNT_WIDTH    = 8;

  localparam logic [CFG_WIDTH-1:0] REPEAT_DELAY_RST    = 16'd350;
  localparam logic [CFG_WIDTH-1:0] REPEAT_INTERVAL_RST = 16'd100;
  localparam logic [CFG_WIDTH-1:0] RELEASE_TIMEOUT_RST = 16'd500;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_REPEAT_DELAY    = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_REPEAT_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_RELEASE_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_REPEAT  = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  // results produced by one item: count (0..2) and kind of each
  typedef struct packed {
    logic [1:0] n;
    kind_t      kind0;
    kind_t      kind1;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rkr_core.sv =====
// Decision core: configuration registers, held-key state, elapsed counters
// and the per-item event decision. Depends on rkr_pkg.
`default_nettype none

module rkr_core #(
  parameter int KEY_WIDTH  = rkr_pkg::KEY_WIDTH_DEF,
  parameter int TIME_WIDTH = rkr_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rkr_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [rkr_pkg::CFG_WIDTH-1:0]     cfg_data,
  input  wire logic                             fire,
  input  wire logic                             mode,
  input  wire logic [rkr_pkg::COUNT_WIDTH-1:0]   repeat_count,
  input  wire logic [KEY_WIDTH-1:0]              key_code,
  output rkr_pkg::ctl_t                          ctl,
  output logic [KEY_WIDTH-1:0]                   key0,
  output logic [KEY_WIDTH-1:0]                   key1
);
  import rkr_pkg::*;

  localparam int CMP_W = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

  logic [CFG_WIDTH-1:0]  repeat_delay;
  logic [CFG_WIDTH-1:0]  repeat_interval;
  logic [CFG_WIDTH-1:0]  release_timeout;

  logic [KEY_WIDTH-1:0]  held_key, held_key_next;
  logic                  held_valid, held_valid_next;
  logic                  repeating, repeating_next;
  logic [TIME_WIDTH-1:0] since_first_press, since_first_press_next;
  logic [TIME_WIDTH-1:0] since_last_event, since_last_event_next;

  logic [TIME_WIDTH-1:0] sfp_inc, sle_inc;
  logic                  first_early, last_early, release_due;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay    <= REPEAT_DELAY_RST;
      repeat_interval <= REPEAT_INTERVAL_RST;
      release_timeout <= RELEASE_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REPEAT_DELAY:    repeat_delay    <= cfg_data;
        REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        REG_RELEASE_TIMEOUT: release_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sfp_inc = (since_first_press == '1) ? since_first_press : since_first_press + 1'b1;
  assign sle_inc = (since_last_event == '1) ? since_last_event : since_last_event + 1'b1;

  assign first_early = CMP_W'(since_first_press) < CMP_W'(repeat_delay);
  assign last_early  = CMP_W'(since_last_event) < CMP_W'(repeat_interval);
  assign release_due = CMP_W'(sle_inc) >= CMP_W'(release_timeout);

  always_comb begin
    held_key_next          = held_key;
    held_valid_next        = held_valid;
    repeating_next         = repeating;
    since_first_press_next = since_first_press;
    since_last_event_next  = since_last_event;
    ctl.n     = 2'd0;
    ctl.kind0 = KIND_PRESS;
    ctl.kind1 = KIND_PRESS;
    key0      = key_code;
    key1      = key_code;
    if (!mode) begin
      since_first_press_next = sfp_inc;
      since_last_event_next  = sle_inc;
      if (repeating && release_due) begin
        ctl.n           = 2'd1;
        ctl.kind0       = KIND_RELEASE;
        key0            = held_key;
        repeating_next  = 1'b0;
        held_valid_next = 1'b0;
      end
    end else if (repeat_count == '0) begin
      if (!(held_valid && key_code == held_key && first_early)) begin
        if (repeating) begin
          ctl.n     = 2'd2;
          ctl.kind0 = KIND_RELEASE;
          key0      = held_key;
        end else begin
          ctl.n = 2'd1;
        end
        held_key_next          = key_code;
        held_valid_next        = 1'b1;
        repeating_next         = 1'b0;
        since_first_press_next = '0;
        since_last_event_next  = '0;
      end
    end else if (!last_early && !first_early) begin
      ctl.n                 = 2'd1;
      ctl.kind0             = KIND_REPEAT;
      repeating_next        = 1'b1;
      since_last_event_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_key          <= '0;
      held_valid        <= 1'b0;
      repeating         <= 1'b0;
      since_first_press <= '0;
      since_last_event  <= '0;
    end else if (fire) begin
      held_key          <= held_key_next;
      held_valid        <= held_valid_next;
      repeating         <= repeating_next;
      since_first_press <= since_first_press_next;
      since_last_event  <= since_last_event_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/remote_key_repeat_filter.sv =====
// Remote key repeat filter, top level: input register, decision core and a
// two-beat result buffer. Depends on rkr_pkg and rkr_core.
// An accepted beat waits in the input register, then its results go to the
// result buffer. Throughput: 1 beat per cycle while results are taken; a beat
// giving a release and a press holds the input while the two-entry result buffer drains.
// Reset (synchronous): buffers empty, state cleared, registers at defaults.
`default_nettype none

module remote_key_repeat_filter #(
  parameter int KEY_WIDTH  = rkr_pkg::KEY_WIDTH_DEF,
  parameter int TIME_WIDTH = rkr_pkg::TIME_WIDTH_DEF,
  localparam int IN_DATA_W  = ((rkr_pkg::COUNT_WIDTH + KEY_WIDTH + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((KEY_WIDTH + 7) / 8) * 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rkr_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [rkr_pkg::CFG_WIDTH-1:0]     cfg_data,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]              s_axis_tdata,  // repeat_count, key_code
  input  wire logic                             s_axis_tuser,  // mode
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [OUT_DATA_W-1:0]                  m_axis_tdata,  // key_id
  output logic [1:0]                             m_axis_tuser,  // event_kind
  output logic                                  m_axis_tlast
);
  import rkr_pkg::*;

  logic                   in_valid;
  logic                   in_mode;
  logic [COUNT_WIDTH-1:0] in_count;
  logic [KEY_WIDTH-1:0]   in_key;

  logic                   accept, pop, fire;
  ctl_t                   ctl;
  logic [KEY_WIDTH-1:0]   key0, key1;

  logic [1:0]             q_count;
  logic [KEY_WIDTH-1:0]   q_key0, q_key1;
  kind_t                  q_kind0, q_kind1;
  logic                   q_last0, q_last1;

  assign pop    = m_axis_tvalid && m_axis_tready;
  assign fire   = in_valid && (q_count == 2'd0 || (q_count == 2'd1 && pop));
  assign s_axis_tready = !in_valid || fire;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_mode  <= s_axis_tuser;
      in_count <= s_axis_tdata[COUNT_WIDTH-1:0];
      in_key   <= s_axis_tdata[COUNT_WIDTH +: KEY_WIDTH];
    end
  end

  rkr_core #(
    .KEY_WIDTH  (KEY_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fire         (fire),
    .mode         (in_mode),
    .repeat_count (in_count),
    .key_code     (in_key),
    .ctl          (ctl),
    .key0         (key0),
    .key1         (key1)
  );

  // fire only when the buffer is empty after this cycle's pop
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
    end else if (fire) begin
      q_count <= ctl.n;
    end else if (pop) begin
      q_count <= q_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      q_key0  <= key0;
      q_kind0 <= ctl.kind0;
      q_last0 <= (ctl.n == 2'd1);
      q_key1  <= key1;
      q_kind1 <= ctl.kind1;
      q_last1 <= 1'b1;
    end else if (pop) begin
      q_key0  <= q_key1;
      q_kind0 <= q_kind1;
      q_last0 <= q_last1;
    end
  end

  assign m_axis_tvalid = (q_count != 2'd0);
  assign m_axis_tdata  = OUT_DATA_W'(q_key0);
  assign m_axis_tuser  = q_kind0;
  assign m_axis_tlast  = q_last0;

endmodule

`default_nettype wire

// ===== hw/rtl/rkr_checker.sv =====
// Port-level checks for the remote key repeat filter, bound to the top level.
// Depends on rkr_pkg and remote_key_repeat_filter.
`default_nettype none

module rkr_checker #(
  parameter int KEY_WIDTH  = rkr_pkg::KEY_WIDTH_DEF,
  parameter int OUT_DATA_W = ((KEY_WIDTH + 7) / 8) * 8
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]            m_axis_tuser,
  input wire logic                  m_axis_tlast
);
  import rkr_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat shown after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == KIND_PRESS || m_axis_tuser == KIND_REPEAT ||
                       m_axis_tuser == KIND_RELEASE))
    else $error("unknown event kind");

  // a release that is not last of its run is always followed by the press
  a_release_then_press: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_RELEASE && !m_axis_tlast)
    |=> (m_axis_tvalid && m_axis_tuser == KIND_PRESS && m_axis_tlast))
    else $error("release not followed by press");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result beat withdrawn");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      ($stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("stalled result beat changed");

endmodule

bind remote_key_repeat_filter rkr_checker #(
  .KEY_WIDTH (KEY_WIDTH)
) u_rkr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for remote_key_repeat_filter: drives tick and key-frame beats,
// predicts press/repeat/release events and checks every result beat in order.
// Depends on rkr_pkg and the remote_key_repeat_filter RTL.
`timescale 1ns / 100ps

module tb_top;
  import rkr_pkg::*;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_FRAME = 1'b1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE = 2'd3;
  localparam logic [15:0] TIME_MAX = 16'hFFFF;
  localparam int PREDICT         = -1;
  localparam int DRAIN_CYCLES    = 6;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int PHASES          = 6;
  localparam int BEATS_PER_PHASE = 300;
  localparam int TOP_TICKS       = 4;

  typedef struct packed {
    logic [31:0] key;
    kind_t       kind;
    logic        last;
  } key_event_t;

  typedef enum logic {ROW_BEAT, ROW_LIMITS} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        mode;
    logic [7:0]  count;
    logic [31:0] key;
    logic [15:0] delay;
    logic [15:0] interval;
    logic [15:0] timeout;
    int          n_typed;
    key_event_t  ev0;
    key_event_t  ev1;
  } stim_row_t;

  localparam key_event_t NO_EV = '{32'd0, KIND_PRESS, 1'b0};

  localparam int DIRECTED_ROWS = 27;
  localparam stim_row_t DIRECTED[DIRECTED_ROWS] = '{
    // register defaults straight out of reset
    '{ROW_BEAT, MODE_FRAME, 8'd1, 32'h1234_5678, 16'd0, 16'd0, 16'd0, 0, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_TICK, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0, 0, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_FRAME, 8'd0, 32'h0000_0000, 16'd0, 16'd0, 16'd0, 1,
      '{32'h0000_0000, KIND_PRESS, 1'b1}, NO_EV},
    '{ROW_BEAT, MODE_FRAME, 8'd0, 32'h0000_0000, 16'd0, 16'd0, 16'd0, 0, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_FRAME, 8'd0, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 1,
      '{32'hFFFF_FFFF, KIND_PRESS, 1'b1}, NO_EV},
    '{ROW_BEAT, MODE_FRAME, 8'd255, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 0, NO_EV, NO_EV},
    // all limits zero
    '{ROW_LIMITS, MODE_TICK, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_FRAME, 8'd1, 32'hA5A5_A5A5, 16'd0, 16'd0, 16'd0, 1,
      '{32'hA5A5_A5A5, KIND_REPEAT, 1'b1}, NO_EV},
    '{ROW_BEAT, MODE_FRAME, 8'd0, 32'h5A5A_5A5A, 16'd0, 16'd0, 16'd0, 2,
      '{32'hFFFF_FFFF, KIND_RELEASE, 1'b0}, '{32'h5A5A_5A5A, KIND_PRESS, 1'b1}},
    '{ROW_BEAT, MODE_FRAME, 8'd0, 32'h5A5A_5A5A, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_FRAME, 8'd128, 32'h0F0F_0F0F, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_TICK, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_TICK, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    // short limits: early repeats, same-key press, idle release
    '{ROW_LIMITS, MODE_TICK, 8'd0, 32'd0, 16'd2, 16'd1, 16'd3, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_FRAME, 8'd0, 32'h0000_0011, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_FRAME, 8'd1, 32'h0000_0011, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_TICK, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_FRAME, 8'd1, 32'h0000_0011, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_TICK, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_FRAME, 8'd2, 32'h0000_0011, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_FRAME, 8'd0, 32'h0000_0011, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_TICK, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_TICK, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_FRAME, 8'd64, 32'h8000_0000, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_TICK, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_TICK, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV},
    '{ROW_BEAT, MODE_TICK, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0, PREDICT, NO_EV, NO_EV}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0]     cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // repeat_count [7:0], key_code [39:8]
  logic        s_axis_tuser = 1'b0; // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // key_id
  logic [1:0]  m_axis_tuser;        // event_kind
  logic        m_axis_tlast;

  // predictor state
  logic [15:0] delay_ms    = REPEAT_DELAY_RST;
  logic [15:0] interval_ms = REPEAT_INTERVAL_RST;
  logic [15:0] timeout_ms  = RELEASE_TIMEOUT_RST;
  logic [31:0] held_code   = '0;
  logic        code_held   = 1'b0;
  logic        key_repeating = 1'b0;
  logic [15:0] press_age   = '0;
  logic [15:0] event_age   = '0;

  key_event_t  predicted[$];
  key_event_t  pending_events[$];
  logic [31:0] key_pool[4];
  bit          steady = 1'b0;
  int          mismatch_count = 0;
  int          beats_sent = 0;
  int          stalled_cycles = 0;

  remote_key_repeat_filter DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void predict_key_events(input logic mode, input logic [7:0] count,
                                             input logic [31:0] key);
    predicted.delete();
    if (mode == MODE_TICK) begin
      press_age = (press_age == TIME_MAX) ? press_age : press_age + 16'd1;
      event_age = (event_age == TIME_MAX) ? event_age : event_age + 16'd1;
      if (key_repeating && event_age >= timeout_ms) begin
        predicted.push_back('{held_code, KIND_RELEASE, 1'b0});
        key_repeating = 1'b0;
        code_held = 1'b0;
      end
    end else if (count == 8'd0) begin
      if (code_held && key == held_code && press_age < delay_ms) return;
      if (key_repeating) predicted.push_back('{held_code, KIND_RELEASE, 1'b0});
      held_code = key;
      code_held = 1'b1;
      key_repeating = 1'b0;
      press_age = '0;
      event_age = '0;
      predicted.push_back('{key, KIND_PRESS, 1'b0});
    end else begin
      if (event_age < interval_ms || press_age < delay_ms) return;
      key_repeating = 1'b1;
      event_age = '0;
      predicted.push_back('{key, KIND_REPEAT, 1'b0});
    end
    if (predicted.size() > 0) predicted[predicted.size() - 1].last = 1'b1;
  endfunction

  function automatic void report_fault(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  task automatic send_beat(input logic mode, input logic [7:0] count, input logic [31:0] key,
                           input int n_typed = PREDICT, input key_event_t t0 = NO_EV,
                           input key_event_t t1 = NO_EV);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {key, count};
    s_axis_tuser  <= mode;
    do @(posedge clk); while (!s_axis_tready);
    predict_key_events(mode, count, key);
    if (n_typed == PREDICT) begin
      foreach (predicted[i]) pending_events.push_back(predicted[i]);
    end else begin
      if (n_typed > 0) pending_events.push_back(t0);
      if (n_typed > 1) pending_events.push_back(t1);
    end
    beats_sent++;
  endtask

  // hold the sender until every predicted event is out and the pipe is empty
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_limits(input logic [15:0] delay, input logic [15:0] interval,
                                input logic [15:0] timeout);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_REPEAT_DELAY;
    cfg_data  <= delay;
    @(posedge clk);
    cfg_index <= REG_REPEAT_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    cfg_index <= REG_RELEASE_TIMEOUT;
    cfg_data  <= timeout;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    delay_ms    = delay;
    interval_ms = interval;
    timeout_ms  = timeout;
  endtask

  // press, a run of repeats spaced by ticks, then maybe idle long enough to release; or a short burst of random beats
  task automatic run_key_session();
    logic [31:0] key;
    int          reps;
    int          span;
    steady = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 24) == 0) drain_results();
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 5))
        send_beat(1'($urandom_range(0, 1)),
                  ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom), $urandom);
      return;
    end
    key = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 3)];
    send_beat(MODE_FRAME, 8'd0, key);
    reps = $urandom_range(0, 6);
    for (int r = 0; r < reps; r++) begin
      span = (r == 0 && delay_ms > interval_ms) ? int'(delay_ms) : int'(interval_ms);
      repeat ($urandom_range(0, span + 2)) send_beat(MODE_TICK, 8'($urandom), $urandom);
      send_beat(MODE_FRAME, 8'($urandom_range(1, 255)),
                ($urandom_range(0, 7) == 0) ? $urandom : key);
    end
    if ($urandom_range(0, 1) == 1)
      repeat ($urandom_range(0, int'(timeout_ms) + 3))
        send_beat(MODE_TICK, 8'($urandom), $urandom);
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_LIMITS)
        program_limits(DIRECTED[r].delay, DIRECTED[r].interval, DIRECTED[r].timeout);
      else
        send_beat(DIRECTED[r].mode, DIRECTED[r].count, DIRECTED[r].key,
                  DIRECTED[r].n_typed, DIRECTED[r].ev0, DIRECTED[r].ev1);
    end

    for (int p = 0; p < PHASES; p++) begin
      program_limits(16'($urandom_range(0, p == 0 ? 4 : 30)),
                     16'($urandom_range(0, p == 0 ? 3 : 15)),
                     16'($urandom_range(0, p == 0 ? 5 : 40)));
      while (beats_sent < DIRECTED_ROWS + (p + 1) * BEATS_PER_PHASE) run_key_session();
    end

    // top limits: same-key presses and repeats held back throughout
    program_limits(TIME_MAX, TIME_MAX, TIME_MAX);
    steady = 1'b1;
    send_beat(MODE_FRAME, 8'd0, key_pool[0]);
    repeat (TOP_TICKS) send_beat(MODE_TICK, 8'($urandom), $urandom);
    send_beat(MODE_FRAME, 8'd1, key_pool[0]);
    send_beat(MODE_FRAME, 8'd0, key_pool[0]);
    send_beat(MODE_FRAME, 8'd0, key_pool[1]);
    send_beat(MODE_FRAME, 8'd255, key_pool[1]);
    steady = 1'b0;

    drain_results();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    key_event_t want;
    int         stall;
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (pending_events.size() == 0) begin
        report_fault($sformatf("unexpected beat: key %h kind %0d last %0d",
                               m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tdata != want.key || m_axis_tuser != want.kind ||
            m_axis_tlast != want.last)
          report_fault($sformatf("expected key %h kind %0d last %0d, got key %h kind %0d last %0d",
                                 want.key, want.kind, want.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles == WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

// ===== remote_key_repeat_filter.f =====
hw/rtl/rkr_pkg.sv
hw/rtl/rkr_core.sv
hw/rtl/remote_key_repeat_filter.sv
hw/rtl/rkr_checker.sv
dv/tb_top.sv
